// File: src/fcs_pkg.sv
// Types, command words and item builders for the flash command sequencer.
// No dependencies; used by fcs_seq, fcs_out_reg and the top level.
package fcs_pkg;

  localparam int ADDR_W = 26;
  localparam int DATA_W = 32;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] word_t;

  // input opcodes (five to seven are ignored)
  localparam logic [2:0] OP_PROGRAM   = 3'd0;
  localparam logic [2:0] OP_ERASE     = 3'd1;
  localparam logic [2:0] OP_READ_ID   = 3'd2;
  localparam logic [2:0] OP_READ_LOCK = 3'd3;
  localparam logic [2:0] OP_READ_DATA = 3'd4;

  // completion status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_PROG_ERR   = 3'd1;
  localparam logic [2:0] ST_ERASE_ERR  = 3'd2;
  localparam logic [2:0] ST_UNLOCK_ERR = 3'd3;
  localparam logic [2:0] ST_BUSY       = 3'd4;

  // both x16 halves carry the same command
  localparam word_t CMD_READ_ARRAY   = 32'h00ff_00ff;
  localparam word_t CMD_PROGRAM      = 32'h0040_0040;
  localparam word_t CMD_STATUS_READ  = 32'h0070_0070;
  localparam word_t CMD_STATUS_CLEAR = 32'h0050_0050;
  localparam word_t CMD_ERASE        = 32'h0020_0020;
  localparam word_t CMD_CONFIRM      = 32'h00d0_00d0;
  localparam word_t CMD_LOCK_SETUP   = 32'h0060_0060;
  localparam word_t CMD_READ_ID      = 32'h0090_0090;
  localparam word_t SR_READY         = 32'h0080_0080;
  localparam word_t SR_PROG_ERR      = 32'h0010_0010;
  localparam word_t SR_ERASE_ERR     = 32'h0020_0020;
  localparam addr_t LOCK_OFFSET      = 26'h8;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PROG_POLL,
    PH_PROG_CHECK,
    PH_UNLOCK_WAIT,
    PH_ERASE_POLL,
    PH_ERASE_CHECK,
    PH_ID_WAIT,
    PH_LOCK_WAIT
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    addr_t      bus_address;
    word_t      bus_data;
    logic [2:0] status;
    word_t      value;
    logic       last;
  } result_t;

  typedef struct packed {
    phase_t phase;
    addr_t  target;
    logic   unlock_bad;
  } state_t;

  function automatic result_t bus_wr(addr_t a, word_t d);
    result_t r;
    r = '0;
    r.kind = KIND_WRITE;
    r.bus_address = a;
    r.bus_data = d;
    return r;
  endfunction

  function automatic result_t bus_rd(addr_t a);
    result_t r;
    r = '0;
    r.kind = KIND_READ;
    r.bus_address = a;
    return r;
  endfunction

  function automatic result_t done(addr_t a, logic [2:0] st, word_t v);
    result_t r;
    r = '0;
    r.kind = KIND_DONE;
    r.bus_address = a;
    r.status = st;
    r.value = v;
    return r;
  endfunction

endpackage

// File: src/fcs_seq.sv
// Expands one held item into its list of bus accesses and completion,
// and computes the sequencer state left after it. Uses fcs_pkg.
module fcs_seq #(
  parameter logic [25:0] ADDR_MASK = 26'h3ff_ffff
) (
  input  fcs_pkg::state_t  st,
  input  logic [2:0]       op,
  input  fcs_pkg::addr_t   addr,
  input  fcs_pkg::word_t   word,
  input  logic [2:0]       idx,
  output fcs_pkg::result_t item,
  output logic [2:0]       count,
  output fcs_pkg::state_t  st_next
);

  fcs_pkg::result_t list [8];
  fcs_pkg::addr_t   a;
  fcs_pkg::addr_t   lock_addr;
  logic             ready;

  assign a         = st.target;
  assign lock_addr = (addr + fcs_pkg::LOCK_OFFSET) & ADDR_MASK;
  assign ready     = (word & fcs_pkg::SR_READY) == fcs_pkg::SR_READY;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      list[i] = '0;
    end
    count   = 3'd0;
    st_next = st;

    if (op <= fcs_pkg::OP_READ_LOCK) begin
      if (st.phase != fcs_pkg::PH_IDLE) begin
        list[0] = fcs_pkg::done(addr, fcs_pkg::ST_BUSY, '0);
        count   = 3'd1;
      end else begin
        st_next.target = addr;
        list[0] = fcs_pkg::bus_wr('0, fcs_pkg::CMD_READ_ARRAY);
        unique case (op)
          fcs_pkg::OP_PROGRAM: begin
            list[1] = fcs_pkg::bus_wr(addr, fcs_pkg::CMD_PROGRAM);
            list[2] = fcs_pkg::bus_wr(addr, word);
            list[3] = fcs_pkg::bus_wr('0, fcs_pkg::CMD_READ_ARRAY);
            list[4] = fcs_pkg::bus_wr(addr, fcs_pkg::CMD_STATUS_READ);
            list[5] = fcs_pkg::bus_rd(addr);
            count   = 3'd6;
            st_next.phase = fcs_pkg::PH_PROG_POLL;
          end
          fcs_pkg::OP_ERASE: begin
            // unlock the block first
            list[1] = fcs_pkg::bus_wr(addr, fcs_pkg::CMD_STATUS_CLEAR);
            list[2] = fcs_pkg::bus_wr(addr, fcs_pkg::CMD_LOCK_SETUP);
            list[3] = fcs_pkg::bus_wr(addr, fcs_pkg::CMD_CONFIRM);
            list[4] = fcs_pkg::bus_wr(addr, fcs_pkg::CMD_STATUS_READ);
            list[5] = fcs_pkg::bus_rd(addr);
            count   = 3'd6;
            st_next.phase = fcs_pkg::PH_UNLOCK_WAIT;
          end
          fcs_pkg::OP_READ_ID: begin
            list[1] = fcs_pkg::bus_wr(addr, fcs_pkg::CMD_READ_ID);
            list[2] = fcs_pkg::bus_rd(addr);
            count   = 3'd3;
            st_next.phase = fcs_pkg::PH_ID_WAIT;
          end
          default: begin
            list[1] = fcs_pkg::bus_wr(addr, fcs_pkg::CMD_READ_ID);
            list[2] = fcs_pkg::bus_rd(lock_addr);
            count   = 3'd3;
            st_next.phase = fcs_pkg::PH_LOCK_WAIT;
          end
        endcase
      end
    end else if (op == fcs_pkg::OP_READ_DATA) begin
      unique case (st.phase)
        fcs_pkg::PH_PROG_POLL: begin
          if (!ready) begin
            list[0] = fcs_pkg::bus_wr('0, fcs_pkg::CMD_READ_ARRAY);
            list[1] = fcs_pkg::bus_wr(a, fcs_pkg::CMD_STATUS_READ);
            list[2] = fcs_pkg::bus_rd(a);
            count   = 3'd3;
          end else begin
            list[0] = fcs_pkg::bus_wr(a, fcs_pkg::CMD_STATUS_READ);
            list[1] = fcs_pkg::bus_rd(a);
            count   = 3'd2;
            st_next.phase = fcs_pkg::PH_PROG_CHECK;
          end
        end
        fcs_pkg::PH_PROG_CHECK: begin
          if ((word & fcs_pkg::SR_PROG_ERR) != '0) begin
            list[0] = fcs_pkg::bus_wr(a, fcs_pkg::CMD_STATUS_CLEAR);
            list[1] = fcs_pkg::bus_wr(a, fcs_pkg::CMD_STATUS_CLEAR);
            list[2] = fcs_pkg::bus_wr('0, fcs_pkg::CMD_READ_ARRAY);
            list[3] = fcs_pkg::done(a, fcs_pkg::ST_PROG_ERR, '0);
            count   = 3'd4;
          end else begin
            list[0] = fcs_pkg::bus_wr(a, fcs_pkg::CMD_STATUS_CLEAR);
            list[1] = fcs_pkg::bus_wr('0, fcs_pkg::CMD_READ_ARRAY);
            list[2] = fcs_pkg::done(a, fcs_pkg::ST_OK, '0);
            count   = 3'd3;
          end
          st_next.phase = fcs_pkg::PH_IDLE;
        end
        fcs_pkg::PH_UNLOCK_WAIT: begin
          st_next.unlock_bad = (word & fcs_pkg::SR_READY) == '0;
          list[0] = fcs_pkg::bus_wr('0, fcs_pkg::CMD_READ_ARRAY);
          list[1] = fcs_pkg::bus_wr('0, fcs_pkg::CMD_READ_ARRAY);
          list[2] = fcs_pkg::bus_wr(a, fcs_pkg::CMD_STATUS_CLEAR);
          list[3] = fcs_pkg::bus_wr(a, fcs_pkg::CMD_ERASE);
          list[4] = fcs_pkg::bus_wr(a, fcs_pkg::CMD_CONFIRM);
          list[5] = fcs_pkg::bus_wr(a, fcs_pkg::CMD_STATUS_READ);
          list[6] = fcs_pkg::bus_rd(a);
          count   = 3'd7;
          st_next.phase = fcs_pkg::PH_ERASE_POLL;
        end
        fcs_pkg::PH_ERASE_POLL: begin
          list[0] = fcs_pkg::bus_wr(a, fcs_pkg::CMD_STATUS_READ);
          list[1] = fcs_pkg::bus_rd(a);
          count   = 3'd2;
          if (ready) begin
            st_next.phase = fcs_pkg::PH_ERASE_CHECK;
          end
        end
        fcs_pkg::PH_ERASE_CHECK: begin
          list[0] = fcs_pkg::bus_wr('0, fcs_pkg::CMD_READ_ARRAY);
          if ((word & fcs_pkg::SR_ERASE_ERR) != '0) begin
            list[1] = fcs_pkg::done(a, fcs_pkg::ST_ERASE_ERR, '0);
          end else if (st.unlock_bad) begin
            list[1] = fcs_pkg::done(a, fcs_pkg::ST_UNLOCK_ERR, '0);
          end else begin
            list[1] = fcs_pkg::done(a, fcs_pkg::ST_OK, '0);
          end
          count   = 3'd2;
          st_next.phase = fcs_pkg::PH_IDLE;
        end
        fcs_pkg::PH_ID_WAIT, fcs_pkg::PH_LOCK_WAIT: begin
          list[0] = fcs_pkg::done(a, fcs_pkg::ST_OK, word);
          count   = 3'd1;
          st_next.phase = fcs_pkg::PH_IDLE;
        end
        default: begin
          // read data while idle is dropped
        end
      endcase
    end
  end

  always_comb begin
    item      = list[idx];
    item.last = (idx == count - 3'd1);
  end

endmodule

// File: src/fcs_out_reg.sv
// Result register in front of the master-side stream port; packs the
// result item into tdata/tuser/tlast. Uses fcs_pkg.
module fcs_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  fcs_pkg::result_t item,
  output logic             load_ready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [95:0]      m_tdata,
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);

  fcs_pkg::result_t held;

  assign load_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_ready) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ready) begin
      held <= item;
    end
  end

  assign m_tdata = {3'b000, held.value, held.status, held.bus_data, held.bus_address};
  assign m_tuser = held.kind;
  assign m_tlast = held.last;

endmodule

// File: src/flash_command_sequencer_core.sv
// Command sequencer for a paired x16 CFI flash on a 32-bit bus.
// Top level: input register, step counter, state, fcs_seq and fcs_out_reg.
//
// Each slave-side transfer is a request (program word, erase block, read id,
// read lock word) or the data returned by a bus read the block asked for.
// The block answers with a run of master-side transfers, ended by tlast:
// bus writes, bus read requests and a completion carrying status and value.
// A held item produces one result per cycle through the output register,
// unless that register is stalled by m_tready; it has 1 to 7 results, or
// none, and the next item is taken in the cycle its last result is handed
// to the output register (at once if it has none). Requests while a job is
// running complete at once with status "rejected busy"; read data while
// idle and unknown opcodes are dropped.
module flash_command_sequencer_core #(
  parameter int ADDR_BITS = 26
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [25:0] address, [57:26] word, [63:58] zero
  input  logic [2:0]  s_tuser,   // [2:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // [25:0] bus_address, [57:26] bus_data,
                                 // [60:58] status, [92:61] value, [95:93] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast
);

  localparam int AddrW = fcs_pkg::ADDR_W;
  localparam int MaskBits = (ADDR_BITS < AddrW) ? ADDR_BITS : AddrW;
  localparam logic [63:0] MaskWide = (64'd1 << MaskBits) - 64'd1;
  localparam logic [AddrW-1:0] AddrMask = MaskWide[AddrW-1:0];

  logic             hold_valid;
  logic [2:0]       hold_op;
  fcs_pkg::addr_t   hold_addr;
  fcs_pkg::word_t   hold_word;
  logic [2:0]       idx;
  fcs_pkg::state_t  st;
  fcs_pkg::state_t  st_next;
  fcs_pkg::result_t item;
  logic [2:0]       count;
  logic             out_ready;
  logic             emit;
  logic             finish;
  logic             in_xfer;

  fcs_seq #(
    .ADDR_MASK(AddrMask)
  ) u_seq (
    .st      (st),
    .op      (hold_op),
    .addr    (hold_addr),
    .word    (hold_word),
    .idx     (idx),
    .item    (item),
    .count   (count),
    .st_next (st_next)
  );

  assign emit     = hold_valid && (count != 3'd0) && out_ready;
  assign finish   = hold_valid && ((count == 3'd0) || (out_ready && item.last));
  assign s_tready = !hold_valid || finish;
  assign in_xfer  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid    <= 1'b0;
      idx           <= '0;
      st.phase      <= fcs_pkg::PH_IDLE;
      st.target     <= '0;
      st.unlock_bad <= 1'b0;
    end else begin
      if (finish) begin
        st <= st_next;
      end
      if (in_xfer) begin
        hold_valid <= 1'b1;
        idx        <= '0;
      end else if (finish) begin
        hold_valid <= 1'b0;
      end else if (emit) begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hold_op   <= s_tuser;
      hold_addr <= s_tdata[25:0] & AddrMask;
      hold_word <= s_tdata[57:26];
    end
  end

  fcs_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (hold_valid && (count != 3'd0)),
    .item       (item),
    .load_ready (out_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule
